FILE: sv/integer_sort_engine_macros.svh
// Assertion macros for the checker file of the sort engine.
`ifndef INTEGER_SORT_ENGINE_MACROS_SVH
`define INTEGER_SORT_ENGINE_MACROS_SVH

// A property that must hold in the same cycle as its trigger.
`define ISE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// A property whose consequence must hold in the cycle after its trigger.
`define ISE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ise_pkg.sv
`default_nettype none

package ise_pkg;

  // Capacity of the cell chain and derived widths.
  localparam int MAX_ITEMS = 64;
  localparam int DATA_W    = 32;
  localparam int RANK_W    = 6;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  // One input beat.
  typedef struct packed {
    logic signed [DATA_W-1:0] sample_value;
    logic                     set_end;
  } sample_t;

  // One result beat.
  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic [RANK_W-1:0]        rank;
    logic                     run_end;
    logic                     overflowed;
  } result_t;

  // Controls broadcast along the chain.
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

  // Controller states.
  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } ise_state_t;

endpackage

`default_nettype wire

FILE: sv/ise_cell.sv
`default_nettype none

module ise_cell import ise_pkg::*; (
  input  wire logic                     clk,
  input  wire cell_ctrl_t               ctrl,
  input  wire logic                     occupied,
  input  wire logic signed [DATA_W-1:0] new_value,
  input  wire logic signed [DATA_W-1:0] left_value,
  input  wire logic                     left_gt,
  input  wire logic signed [DATA_W-1:0] right_value,
  output logic signed [DATA_W-1:0]      value,
  output logic                          gt
);

  // The held element is larger than the incoming one, so it must move right.
  always_comb begin
    gt = occupied && (value > new_value);
  end

  // Drain shifts towards the head; insertion either takes the left
  // neighbour's element, takes the new element, or keeps what is held.
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      value <= right_value;
    end else if (ctrl.insert) begin
      if (left_gt) begin
        value <= left_value;
      end else if (gt || !occupied) begin
        value <= new_value;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/integer_sort_engine.sv
// Sort engine for sets of signed 32-bit integers.
// Input: a beat is taken at each rising edge with start high and busy low.
// Each beat carries one element and set_end, which marks the last of a set.
// Elements go into a chain of MAX_ITEMS compare-and-keep cells, which keeps
// the set in ascending order as it loads, one element per cycle.
// Elements beyond capacity are dropped and the set's results are flagged.
// After the set_end beat, busy rises and stays high while the chain
// shifts one element per cycle towards its head, once per stored element.
// Results: one beat per cycle on result, marked by strobe for one cycle;
// the first is loaded from the head cell into the result and strobe
// registers after the state register enters the drain; the last carries
// run_end. The receiver cannot stall, so the drain never pauses.
// A set occupies the block while its beats are taken and while its stored
// elements drain; the next set may start in the cycle of the last result.
// Reset empties the chain and clears the overflow flag; the cells' contents
// are not cleared, as only occupied cells are ever read.
`default_nettype none

module integer_sort_engine import ise_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  output logic         busy,
  input  wire sample_t sample,
  output result_t      result,
  output logic         strobe
);

  ise_state_t              state, state_next;
  logic [CNT_W-1:0]        count, count_next;
  logic                    overflow, overflow_next;
  logic [RANK_W-1:0]       rank_cnt, rank_cnt_next;
  result_t                 result_next;
  logic                    strobe_next;
  logic                    accept;
  logic                    room;
  cell_ctrl_t              ctrl;

  logic signed [DATA_W-1:0] cell_value [MAX_ITEMS];
  logic                     cell_gt    [MAX_ITEMS];

  assign busy   = (state == ST_DRAIN);
  assign accept = start && !busy;
  assign room   = (count < CNT_W'(MAX_ITEMS));

  // Chain of cells, each wired to its neighbours; the head and tail ends are tied off.
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_v;
    logic signed [DATA_W-1:0] right_v;
    logic                     left_g;
    logic                     occ;

    if (i == 0) begin : g_head
      assign left_v = '0;
      assign left_g = 1'b0;
    end else begin : g_body
      assign left_v = cell_value[i-1];
      assign left_g = cell_gt[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign right_v = '0;
    end else begin : g_inner
      assign right_v = cell_value[i+1];
    end

    assign occ = (CNT_W'(i) < count);

    ise_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (occ),
      .new_value   (sample.sample_value),
      .left_value  (left_v),
      .left_gt     (left_g),
      .right_value (right_v),
      .value       (cell_value[i]),
      .gt          (cell_gt[i])
    );
  end

  // Control state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      count    <= '0;
      overflow <= 1'b0;
      rank_cnt <= '0;
      strobe   <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      overflow <= overflow_next;
      rank_cnt <= rank_cnt_next;
      strobe   <= strobe_next;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    result <= result_next;
  end

  // Next state, chain controls and the next result beat.
  always_comb begin
    state_next    = state;
    count_next    = count;
    overflow_next = overflow;
    rank_cnt_next = rank_cnt;
    strobe_next   = 1'b0;
    result_next   = result;
    ctrl.insert   = 1'b0;
    ctrl.shift    = 1'b0;
    unique case (state)
      ST_LOAD: begin
        if (accept) begin
          if (room) begin
            ctrl.insert = 1'b1;
            count_next  = count + CNT_W'(1);
          end else begin
            overflow_next = 1'b1;
          end
          if (sample.set_end) begin
            state_next    = ST_DRAIN;
            rank_cnt_next = '0;
          end
        end
      end
      ST_DRAIN: begin
        ctrl.shift               = 1'b1;
        strobe_next              = 1'b1;
        result_next.sorted_value = cell_value[0];
        result_next.rank         = rank_cnt;
        result_next.run_end      = (count == CNT_W'(1));
        result_next.overflowed   = overflow;
        rank_cnt_next            = rank_cnt + RANK_W'(1);
        count_next               = count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          state_next    = ST_LOAD;
          overflow_next = 1'b0;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/ise_checker.sv
`default_nettype none
`include "integer_sort_engine_macros.svh"

module ise_checker import ise_pkg::*; (
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    start,
  input wire logic    busy,
  input wire sample_t sample,
  input wire result_t result,
  input wire logic    strobe
);

  // Closing a set starts the drain at once.
  `ISE_ASSERT_NEXT(a_end_starts_drain, start && !busy && sample.set_end, busy, "set end did not raise busy")

  // Results of one set come back to back with ranks counting up.
  `ISE_ASSERT_NEXT(a_rank_steps, strobe && !result.run_end, strobe && (result.rank == $past(result.rank) + RANK_W'(1)), "rank did not step by one")

  // Results of one set are in ascending signed order.
  `ISE_ASSERT_NEXT(a_ascending, strobe && !result.run_end, $signed(result.sorted_value) >= $signed($past(result.sorted_value)), "results out of order")

  // The drain ends together with the last beat of the set.
  `ISE_ASSERT_NOW(a_end_with_last, $fell(busy), strobe && result.run_end, "busy fell without a last result")

endmodule

bind integer_sort_engine ise_checker u_checker (.*);

`default_nettype wire
